### rtl/core/http_header_length_scanner_unit_macros.svh
// Assertion macros shared by the scanner RTL.
// Each macro expects clk and rst to be visible at the place of use.
`ifndef HTTP_HEADER_LENGTH_SCANNER_UNIT_MACROS_SVH
`define HTTP_HEADER_LENGTH_SCANNER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define HHLS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scanner assertion failed");
`define HHLS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scanner assertion failed");
`else
`define HHLS_ASSERT_IMP(lbl, ante, cons)
`define HHLS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### rtl/core/hhls_pkg.sv
package hhls_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int KEY_LEN     = 15;
  localparam int Q_DEPTH     = 4;
  localparam int Q_AW        = $clog2(Q_DEPTH);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [34:0]            LEN_MAX   = 35'd2147483647;
  localparam logic [3:0]             KEY_LAST  = 4'(KEY_LEN - 1);

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [7:0] KEY_TEXT [KEY_LEN] = '{
    8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
    8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A
  };

  typedef enum logic [2:0] {
    PH_SEEK   = 3'd0,
    PH_BLANK  = 3'd1,
    PH_DIGITS = 3'd2,
    PH_OK     = 3'd3,
    PH_BAD    = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    V_HEADER = 3'd0,
    V_BODY   = 3'd1,
    V_DONE   = 3'd2,
    V_BADLEN = 3'd3,
    V_LARGE  = 3'd4
  } verdict_t;

  // One received byte after classification.
  typedef struct packed {
    logic        first;
    logic        is_digit;
    logic [3:0]  digit;
    logic        is_blank;
    logic        is_cr;
    logic        is_lf;
    logic [15:0] key_hit;   // bit k: byte equals key character k
  } cls_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [30:0] content_length;
    logic [15:0] header_length;
    logic [15:0] total_length;
  } res_t;

  typedef struct packed {
    logic cr;
    logic lf;
  } tail_t;

endpackage

### rtl/core/hhls_front.sv
module hhls_front import hhls_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_first,
  output logic       push,
  input  logic       push_ready,
  output cls_t       push_item
);

  logic held;
  cls_t item;
  cls_t item_next;

  always_comb begin
    item_next.first    = in_first;
    item_next.is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    item_next.digit    = 4'(in_byte - CH_ZERO);
    item_next.is_blank = (in_byte == CH_SPACE) || (in_byte == CH_TAB);
    item_next.is_cr    = (in_byte == CH_CR);
    item_next.is_lf    = (in_byte == CH_LF);
    item_next.key_hit  = '0;
    for (int k = 0; k < KEY_LEN; k++) begin
      item_next.key_hit[k] = (in_byte == KEY_TEXT[k]);
    end
  end

  assign in_ready  = !held || push_ready;
  assign push      = held;
  assign push_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

### rtl/core/hhls_queue.sv
`include "http_header_length_scanner_unit_macros.svh"

module hhls_queue import hhls_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic push_ready,
  input  cls_t push_item,
  output logic pop_valid,
  input  logic pop,
  output cls_t pop_item
);

  cls_t              slots [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr;
  logic [Q_AW-1:0]   rd_ptr;
  logic [Q_AW:0]     count;

  assign push_ready = (count != (Q_AW + 1)'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && push_ready) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && pop_valid) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push && push_ready, pop && pop_valid})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      slots[wr_ptr] <= push_item;
    end
  end

  `HHLS_ASSERT_IMP(a_no_overflow, push && !push_ready, count == (Q_AW + 1)'(Q_DEPTH))
  `HHLS_ASSERT_IMP(a_no_underflow, pop, pop_valid)
  `HHLS_ASSERT_NXT(a_count_up, push && push_ready && !pop, count == $past(count) + 1'b1)

endmodule

### rtl/core/hhls_back.sv
`include "http_header_length_scanner_unit_macros.svh"

module hhls_back import hhls_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [15:0] cfg_data,
  input  logic        pop_valid,
  output logic        pop,
  input  cls_t        item,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_res
);

  logic [15:0]            max_total;
  tail_t                  t2, t1, t0;
  logic [3:0]             kmc;
  phase_t                 phase;
  logic [30:0]            len;
  logic [COUNT_WIDTH-1:0] bcount;
  logic [15:0]            hbytes;
  verdict_t               vd;

  tail_t                  c_t2, c_t1, c_t0, t2_next, t1_next, t0_next;
  logic [3:0]             c_kmc, kmc_next;
  phase_t                 c_phase, phase_next;
  logic [30:0]            c_len, len_next;
  logic [COUNT_WIDTH-1:0] c_bcount, bcount_next;
  logic [15:0]            c_hbytes, hbytes_next;
  verdict_t               c_vd, vd_next;
  logic [34:0]            prod;
  logic [32:0]            bc_ext;
  logic [32:0]            total;
  logic                   hit;
  res_t                   res_next;

  assign pop = pop_valid && (!out_valid || out_ready);

  always_comb begin
    c_t2     = item.first ? '0 : t2;
    c_t1     = item.first ? '0 : t1;
    c_t0     = item.first ? '0 : t0;
    c_kmc    = item.first ? '0 : kmc;
    c_phase  = item.first ? PH_SEEK : phase;
    c_len    = item.first ? '0 : len;
    c_bcount = item.first ? '0 : bcount;
    c_hbytes = item.first ? '0 : hbytes;
    c_vd     = item.first ? V_HEADER : vd;

    bcount_next = (c_bcount != COUNT_MAX) ? c_bcount + 1'b1 : c_bcount;
    bc_ext      = 33'(bcount_next);
    prod        = (35'(c_len) << 3) + (35'(c_len) << 1) + 35'(item.digit);
    hit         = c_t2.cr && c_t1.lf && c_t0.cr && item.is_lf;

    t2_next     = c_t2;
    t1_next     = c_t1;
    t0_next     = c_t0;
    kmc_next    = c_kmc;
    phase_next  = c_phase;
    len_next    = c_len;
    hbytes_next = c_hbytes;
    vd_next     = c_vd;

    if (c_vd == V_HEADER) begin
      unique case (c_phase)
        PH_SEEK: begin
          if (item.key_hit[c_kmc]) begin
            kmc_next = c_kmc + 1'b1;
            if (c_kmc == KEY_LAST) begin
              phase_next = PH_BLANK;
            end
          end else begin
            kmc_next = item.key_hit[0] ? 4'd1 : 4'd0;
          end
        end
        PH_BLANK: begin
          if (item.is_blank) begin
            phase_next = PH_BLANK;
          end else if (item.is_digit) begin
            len_next   = 31'(item.digit);
            phase_next = PH_DIGITS;
          end else begin
            phase_next = PH_BAD;
          end
        end
        PH_DIGITS: begin
          if (item.is_digit) begin
            if (prod > LEN_MAX) begin
              len_next   = '0;
              phase_next = PH_BAD;
            end else begin
              len_next = prod[30:0];
            end
          end else if (item.is_cr || item.is_lf) begin
            phase_next = PH_OK;
          end else begin
            phase_next = PH_BAD;
          end
        end
        default: phase_next = c_phase;
      endcase

      // The header end byte is LF, so the length is never changed on it.
      if (hit) begin
        hbytes_next = (bc_ext > 33'd65535) ? 16'hFFFF : bc_ext[15:0];
        if (phase_next != PH_OK) begin
          vd_next = V_BADLEN;
        end else if (bc_ext + 33'(c_len) > 33'(max_total)) begin
          vd_next = V_LARGE;
        end else begin
          vd_next = V_BODY;
        end
      end
      t2_next = c_t1;
      t1_next = c_t0;
      t0_next = '{cr: item.is_cr, lf: item.is_lf};
    end

    total = 33'(hbytes_next) + 33'(c_len);
    if (vd_next == V_BODY && bc_ext >= total) begin
      vd_next = V_DONE;
    end

    res_next.status         = vd_next;
    res_next.content_length = (vd_next == V_BODY || vd_next == V_DONE) ? len_next : '0;
    res_next.header_length  = (vd_next == V_HEADER) ? '0 : hbytes_next;
    res_next.total_length   = (vd_next == V_BODY || vd_next == V_DONE || vd_next == V_LARGE)
                              ? ((total > 33'd65535) ? 16'hFFFF : total[15:0]) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_total <= 16'hFFFF;
      t2        <= '0;
      t1        <= '0;
      t0        <= '0;
      kmc       <= '0;
      phase     <= PH_SEEK;
      len       <= '0;
      bcount    <= '0;
      hbytes    <= '0;
      vd        <= V_HEADER;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_total <= cfg_data;
      end
      if (pop) begin
        t2        <= t2_next;
        t1        <= t1_next;
        t0        <= t0_next;
        kmc       <= kmc_next;
        phase     <= phase_next;
        len       <= len_next;
        bcount    <= bcount_next;
        hbytes    <= hbytes_next;
        vd        <= vd_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res <= res_next;
    end
  end

  `HHLS_ASSERT_NXT(a_final_hold,
    pop && !item.first && (vd == V_DONE || vd == V_BADLEN || vd == V_LARGE),
    vd == $past(vd))
  `HHLS_ASSERT_IMP(a_pending_zero, out_valid && out_res.status == V_HEADER,
    out_res.header_length == '0 && out_res.total_length == '0)
  `HHLS_ASSERT_IMP(a_badlen_zero, out_valid && out_res.status == V_BADLEN,
    out_res.content_length == '0 && out_res.total_length == '0)

endmodule

### rtl/core/http_header_length_scanner_unit.sv
// HTTP response length scanner.
// Input stream: one response byte per word on s_tdata, s_tuser high on the
// first byte of a new response, which restarts the scan.
// Output stream: exactly one result word per input word, in order, carrying
// status, parsed content length, header length and total response length.
// Config channel: cfg_data sets the largest header plus body total that is
// accepted; cfg_ready is always high. Write it only while the block is idle.
// An accepted input word passes the classify register, the queue and the
// scanner output register before m_tvalid. Throughput: one word per cycle
// while m_tready stays high; the scanner state update (key match, decimal
// accumulate, length compare) is combinational for each byte.
// Reset: all scan state clears, the limit returns to 65535, no output valid.
// When the receiver stalls, the result holds on m_tdata, the four-entry queue
// fills, and s_tready drops once the queue and classify register are full.
module http_header_length_scanner_unit import hhls_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] first
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [2:0] status, [33:3] content_length,
                                 // [49:34] header_length, [65:50] total_length
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic push;
  logic push_ready;
  cls_t push_item;
  logic pop_valid;
  logic pop;
  cls_t pop_item;
  res_t res;

  hhls_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .in_first   (s_tuser),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  hhls_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  hhls_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .pop_valid (pop_valid),
    .pop       (pop),
    .item      (pop_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign cfg_ready = 1'b1;
  assign m_tdata   = {6'b0, res.total_length, res.header_length,
                      res.content_length, res.status};

endmodule

### tb/sv/tb_http_header_length_scanner_unit.sv
`timescale 1ns / 100ps

module tb_http_header_length_scanner_unit;
  import hhls_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] rx_byte
  logic        s_tuser = 1'b0; // [0] first
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;        // [2:0] status, [33:3] content_length,
                               // [49:34] header_length, [65:50] total_length
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  string CRLF = "\015\012";
  string LF = "\012";
  string STATUS_LINE = "HTTP/1.1 200 OK\015\012";

  // Scanner state mirrored by the predictor
  logic [23:0] scan_tail;
  logic [3:0]  key_pos;
  phase_t      scan_phase;
  logic [35:0] length_acc;
  logic [15:0] byte_total;
  logic [15:0] head_len;
  verdict_t    scan_verdict;
  logic [15:0] total_limit;

  res_t        expected_results[$];
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned hold_off = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned responses_sent = 0;
  int unsigned words_checked = 0;
  int unsigned limit_writes = 0;
  int unsigned status_seen [5];

  http_header_length_scanner_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles,
               expected_results.size());
      $display("http_header_length_scanner_unit: mismatch");
      $finish;
    end
  end

  function automatic void clear_scan();
    scan_tail = '0;
    key_pos = '0;
    scan_phase = PH_SEEK;
    length_acc = '0;
    byte_total = '0;
    head_len = '0;
    scan_verdict = V_HEADER;
  endfunction

  // Advance the mirrored scanner by one byte and return the result word.
  function automatic res_t scan_response_byte(input logic [7:0] b, input logic restart);
    logic        is_digit;
    logic [35:0] total;
    res_t        r;
    if (restart) clear_scan();
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    if (byte_total != COUNT_MAX) byte_total++;
    if (scan_verdict == V_HEADER) begin
      case (scan_phase)
        PH_SEEK: begin
          if (key_pos < KEY_LEN && b == KEY_TEXT[key_pos]) begin
            key_pos++;
            if (key_pos == KEY_LEN) scan_phase = PH_BLANK;
          end else begin
            key_pos = (b == KEY_TEXT[0]) ? 4'd1 : 4'd0;
          end
        end
        PH_BLANK: begin
          if (b == CH_SPACE || b == CH_TAB) begin
            scan_phase = PH_BLANK;
          end else if (is_digit) begin
            length_acc = 36'(b - CH_ZERO);
            scan_phase = PH_DIGITS;
          end else begin
            scan_phase = PH_BAD;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            length_acc = length_acc * 36'd10 + 36'(b - CH_ZERO);
            if (length_acc > 36'(LEN_MAX)) begin
              length_acc = '0;
              scan_phase = PH_BAD;
            end
          end else if (b == CH_CR || b == CH_LF) begin
            scan_phase = PH_OK;
          end else begin
            scan_phase = PH_BAD;
          end
        end
        default: ;
      endcase
      // blank line closes the header
      if ({scan_tail, b} == {CH_CR, CH_LF, CH_CR, CH_LF}) begin
        head_len = byte_total;
        if (scan_phase != PH_OK) begin
          scan_verdict = V_BADLEN;
        end else if (36'(byte_total) + length_acc > 36'(total_limit)) begin
          scan_verdict = V_LARGE;
        end else begin
          scan_verdict = V_BODY;
        end
      end
      scan_tail = {scan_tail[15:0], b};
    end
    total = 36'(head_len) + length_acc;
    if (scan_verdict == V_BODY && 36'(byte_total) >= total) scan_verdict = V_DONE;
    r.status = scan_verdict;
    r.content_length = (scan_verdict == V_BODY || scan_verdict == V_DONE) ?
                       length_acc[30:0] : '0;
    r.header_length = (scan_verdict == V_HEADER) ? '0 : head_len;
    r.total_length = '0;
    if (scan_verdict == V_BODY || scan_verdict == V_DONE || scan_verdict == V_LARGE)
      r.total_length = (total > 36'hFFFF) ? 16'hFFFF : total[15:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [35:0] want,
                             input logic [35:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 40)
        $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t ns: result word expected none, got %h", $time, m_tdata);
      end else begin
        want = expected_results.pop_front();
        words_checked++;
        status_seen[want.status]++;
        check_field("status", 36'(want.status), 36'(m_tdata[2:0]));
        check_field("content_length", 36'(want.content_length), 36'(m_tdata[33:3]));
        check_field("header_length", 36'(want.header_length), 36'(m_tdata[49:34]));
        check_field("total_length", 36'(want.total_length), 36'(m_tdata[65:50]));
      end
    end
  end

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off != 0) begin
      m_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Enter and leave at a falling edge; valid stays high into the next word.
  task automatic send_byte(input logic [7:0] b, input logic restart);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= restart;
    do @(posedge clk); while (s_tready !== 1'b1);
    expected_results.push_back(scan_response_byte(b, restart));
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input logic restart);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], restart && i == 0);
  endtask

  task automatic send_response(input string head, input int unsigned body_n);
    send_text(head, 1'b1);
    repeat (body_n) send_byte(8'($urandom_range(0, 255)), 1'b0);
    responses_sent++;
  endtask

  function automatic string with_length(input string field);
    return {STATUS_LINE, "Content-Length:", field, CRLF, CRLF};
  endfunction

  task automatic write_limit(input logic [15:0] value);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    total_limit = value;
    limit_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 20);
    if (r < 80) return $urandom_range(21, 300);
    if (r < 92) return $urandom_range(301, 70000);
    return $urandom_range(70001, 32'h7FFFFFFF);
  endfunction

  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 30);
    for (int i = 0; i < n; i++)
      send_byte(8'($urandom_range(0, 255)), i == 0 || $urandom_range(0, 15) == 0);
  endtask

  task automatic send_random_response();
    string       head;
    string       value;
    int unsigned pick;
    int unsigned len;
    int unsigned body_n;
    int unsigned blanks;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      send_noise();
      return;
    end
    len = pick_length();
    value = $sformatf("%0d", len);
    head = STATUS_LINE;
    if ($urandom_range(0, 1) != 0) head = {head, "Server: unit", CRLF};
    if (pick < 75) begin
      head = {head, "Content-Length:"};
      blanks = $urandom_range(0, 3);
      repeat (blanks) head = {head, ($urandom_range(0, 1) != 0) ? " " : "\t"};
      head = {head, value};
      // a bare LF also ends the value
      if ($urandom_range(0, 3) == 0) head = {head, LF, "Date: now", CRLF};
      else head = {head, CRLF};
    end else begin
      case ($urandom_range(0, 5))
        0: head = {head, "Content-Length: ", value, "q", CRLF};
        1: head = {head, "Content-Length: ", value, " ", CRLF};
        2: head = {head, "Content-Length: ",
                   $sformatf("%0d", 64'(len) + 64'd2147483648), CRLF};
        3: head = {head, "Content-length: ", value, CRLF};
        4: head = {head, "Content-Length: -", value, CRLF};
        default: head = {head, "Content-LengContent-Length: ", value, CRLF};
      endcase
    end
    if ($urandom_range(0, 1) != 0) head = {head, "Connection: close", CRLF};
    head = {head, CRLF};
    body_n = (len <= 40) ? len + $urandom_range(0, 2) : $urandom_range(0, 40);
    // cut some bodies short so the next response restarts mid-body
    if ($urandom_range(0, 9) == 0) body_n = body_n / 2;
    send_response(head, body_n);
  endtask

  task automatic test_empty_body();
    send_response(with_length(" 0"), 3);
  endtask

  task automatic test_missing_key();
    send_response({STATUS_LINE, "Server: probe", CRLF, CRLF}, 2);
    send_response({STATUS_LINE, "Content-length: 5", CRLF, CRLF}, 1);
  endtask

  task automatic test_length_values();
    send_response(with_length(" abc"), 1);
    send_response(with_length(""), 1);
    send_response(with_length(" 12 "), 1);
    send_response(with_length(" 12x"), 1);
    send_response(with_length(" 2147483648"), 1);
    send_response(with_length(" 2147483647"), 1);
    send_response(with_length("\t \t7"), 7);
    send_response({STATUS_LINE, "Content-Length:3", LF, "Connection: close", CRLF, CRLF}, 3);
    send_response({STATUS_LINE, "CContent-Length: 2", CRLF, CRLF}, 2);
  endtask

  task automatic test_repeated_key();
    send_response({STATUS_LINE, "Content-Length: z", CRLF, "Content-Length: 4", CRLF, CRLF}, 4);
    send_response({STATUS_LINE, "Content-Length: 3", CRLF, "Content-Length: 9", CRLF, CRLF}, 5);
  endtask

  task automatic test_restart();
    send_text({STATUS_LINE, "Content-Len"}, 1'b1);
    send_text(with_length(" 6"), 1'b1);
    repeat (3) send_byte(8'h5A, 1'b0);
    send_response(with_length(" 1"), 1);
    send_byte(8'h0D, 1'b1);
  endtask

  task automatic test_limit_edges();
    string head;
    head = with_length(" 9");
    write_limit(16'(head.len() + 9));
    send_response(head, 9);
    write_limit(16'(head.len() + 8));
    send_response(head, 2);
    write_limit(16'h0000);
    send_response(head, 1);
    send_response(with_length(" 0"), 1);
    write_limit(16'hFFFF);
  endtask

  task automatic test_random_traffic(input int unsigned tx_gap, input int unsigned rx_gap,
                                     input logic [15:0] limit);
    int unsigned stop_at;
    write_limit(limit);
    send_idle = tx_gap;
    recv_idle = rx_gap;
    stop_at = bytes_sent + 80;
    while (bytes_sent < stop_at) send_random_response();
  endtask

  // Hold the result side off long enough for the input side to stall.
  task automatic test_backpressure();
    hold_off <= 100;
    send_response(with_length(" 30"), 30);
    send_response(with_length(" 5"), 5);
  endtask

  initial begin
    total_limit = 16'hFFFF;
    clear_scan();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle = 17;
    recv_idle = 48;
    write_limit(16'hFFFF);
    test_empty_body();
    test_missing_key();
    test_length_values();
    test_repeated_key();
    test_restart();
    test_limit_edges();
    test_random_traffic(17, 48, 16'd200);
    test_random_traffic(48, 17, 16'($urandom_range(60, 2000)));
    test_random_traffic(0, 0, 16'hFFFF);
    test_backpressure();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    $display("Scanned %0d bytes in %0d responses, %0d result words checked, %0d limit writes.",
             bytes_sent, responses_sent, words_checked, limit_writes);
    $display("Words by status: pending %0d, body %0d, complete %0d, bad %0d, too large %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (errors == 0) begin
      $display("http_header_length_scanner_unit: match");
    end else begin
      $display("http_header_length_scanner_unit: mismatch");
    end
    $finish;
  end

endmodule
